FILE: hw/rtl/dqvs_pkg.sv
// Shared types, constants and ring-index helper for the deque with value search.
package dqvs_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_CONTAINS   = 3'd4;
    localparam logic [2:0] REQ_REMOVE     = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SC_RD,
        S_SC_CMP,
        S_SH_RD,
        S_SH_WR,
        S_FB_RD,
        S_OUT
    } state_t;

    // Slot index of the entry at offset off from head (off < DEPTH).
    function automatic logic [IDX_W-1:0] ring_at(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, off};
        if (sum >= (CNT_W + 1)'(DEPTH))
        begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/dqvs_ram.sv
// Slot memory: one write port, two registered read ports.
module dqvs_ram #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 32,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [DATA_W-1:0] rdata_a,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: hw/rtl/deque_with_value_search.sv
// Top level: bounded deque of signed 32-bit values with search and remove-by-value.
// Push, pop, unused codes and searches of an empty deque go through S_FB_RD to S_OUT,
// where done is raised. Contains/remove examine each entry with one RAM read (S_SC_RD)
// and one compare (S_SC_CMP); remove then shifts each later entry with a read and a write
// (S_SH_RD, S_SH_WR). busy stays high through the done cycle, so a new request is only
// taken once the last one is through; done cannot be stalled. Reset empties the deque.
module deque_with_value_search
    import dqvs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               req_type,
    input  logic signed [DATA_W-1:0] item_value,
    output logic                     done,
    output logic                     found,
    output logic [1:0]               status,
    output logic [CNT_W-1:0]         entry_count,
    output logic signed [DATA_W-1:0] front_value,
    output logic signed [DATA_W-1:0] back_value
);

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  head_reg;
    logic [CNT_W-1:0]  occ_reg;
    logic [CNT_W-1:0]  idx_reg;      // offset from head of the entry being worked on
    logic [DATA_W-1:0] value_reg;    // search key
    logic              remove_reg;   // request is a remove, not a plain contains
    logic              found_reg;
    logic [1:0]        status_reg;

    // RAM port controls
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr_a;
    logic [IDX_W-1:0]  ram_raddr_b;
    logic [DATA_W-1:0] ram_rdata_a;
    logic [DATA_W-1:0] ram_rdata_b;

    logic              accept;
    logic              is_full;
    logic              is_empty;
    logic              match;
    logic [CNT_W:0]    idx_p1;
    logic [CNT_W:0]    idx_p2;
    logic              more_scan;    // another entry lies behind idx
    logic              more_shift;   // another shift is needed after this one
    logic [IDX_W-1:0]  head_dec;
    logic [IDX_W-1:0]  head_inc;

    assign accept     = start && (state_reg == S_IDLE);
    assign busy       = (state_reg != S_IDLE);
    assign is_full    = (occ_reg == CNT_W'(DEPTH));
    assign is_empty   = (occ_reg == '0);
    assign match      = (ram_rdata_a == value_reg);
    assign idx_p1     = {1'b0, idx_reg} + (CNT_W + 1)'(1);
    assign idx_p2     = {1'b0, idx_reg} + (CNT_W + 1)'(2);
    assign more_scan  = (idx_p1 < {1'b0, occ_reg});
    assign more_shift = (idx_p2 < {1'b0, occ_reg});
    assign head_dec   = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - IDX_W'(1);
    assign head_inc   = ring_at(head_reg, CNT_W'(1));

    dqvs_ram #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((req_type == REQ_CONTAINS || req_type == REQ_REMOVE) && !is_empty)
                    begin
                        state_next = S_SC_RD;
                    end
                    else
                    begin
                        state_next = S_FB_RD;
                    end
                end
            end
            S_SC_RD:
            begin
                state_next = S_SC_CMP;
            end
            S_SC_CMP:
            begin
                if (match)
                begin
                    state_next = (remove_reg && more_scan) ? S_SH_RD : S_FB_RD;
                end
                else
                begin
                    state_next = more_scan ? S_SC_RD : S_FB_RD;
                end
            end
            S_SH_RD:
            begin
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                state_next = more_shift ? S_SH_RD : S_FB_RD;
            end
            S_FB_RD:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // RAM controls and result ports
    always_comb
    begin
        ram_we      = 1'b0;
        ram_waddr   = ring_at(head_reg, idx_reg);
        ram_wdata   = ram_rdata_a;
        ram_raddr_a = ring_at(head_reg, idx_reg);
        ram_raddr_b = head_reg;
        done        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                ram_wdata = item_value;
                if (accept && !is_full)
                begin
                    if (req_type == REQ_PUSH_FRONT)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = head_dec;
                    end
                    else if (req_type == REQ_PUSH_BACK)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = ring_at(head_reg, occ_reg);
                    end
                end
            end
            S_SC_RD, S_SC_CMP:
            begin
            end
            S_SH_RD:
            begin
                ram_raddr_a = ring_at(head_reg, idx_p1[CNT_W-1:0]);
            end
            S_SH_WR:
            begin
                // entry behind idx moves into idx's slot
                ram_we = 1'b1;
            end
            S_FB_RD:
            begin
                ram_raddr_a = head_reg;
                ram_raddr_b = ring_at(head_reg, occ_reg - CNT_W'(1));
            end
            S_OUT:
            begin
                done = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign found       = found_reg;
    assign status      = status_reg;
    assign entry_count = occ_reg;
    assign front_value = is_empty ? '0 : ram_rdata_a;
    assign back_value  = is_empty ? '0 : ram_rdata_b;

    // Control and bookkeeping registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            occ_reg    <= '0;
            found_reg  <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        found_reg  <= 1'b0;
                        status_reg <= ST_OK;
                        case (req_type)
                            REQ_PUSH_FRONT:
                            begin
                                if (is_full)
                                begin
                                    status_reg <= ST_FULL;
                                end
                                else
                                begin
                                    head_reg <= head_dec;
                                    occ_reg  <= occ_reg + CNT_W'(1);
                                end
                            end
                            REQ_PUSH_BACK:
                            begin
                                if (is_full)
                                begin
                                    status_reg <= ST_FULL;
                                end
                                else
                                begin
                                    occ_reg <= occ_reg + CNT_W'(1);
                                end
                            end
                            REQ_POP_FRONT:
                            begin
                                if (is_empty)
                                begin
                                    status_reg <= ST_EMPTY;
                                end
                                else
                                begin
                                    head_reg <= head_inc;
                                    occ_reg  <= occ_reg - CNT_W'(1);
                                end
                            end
                            REQ_POP_BACK:
                            begin
                                if (is_empty)
                                begin
                                    status_reg <= ST_EMPTY;
                                end
                                else
                                begin
                                    occ_reg <= occ_reg - CNT_W'(1);
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_SC_CMP:
                begin
                    if (match)
                    begin
                        found_reg <= 1'b1;
                        if (remove_reg && !more_scan)
                        begin
                            occ_reg <= occ_reg - CNT_W'(1);
                        end
                    end
                end
                S_SH_WR:
                begin
                    if (!more_shift)
                    begin
                        occ_reg <= occ_reg - CNT_W'(1);
                    end
                end
                S_SC_RD, S_SH_RD, S_FB_RD, S_OUT:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // Request payload captured at accept; idx walks the scan and the shift
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg  <= item_value;
            remove_reg <= (req_type == REQ_REMOVE);
            idx_reg    <= '0;
        end
        else if ((state_reg == S_SC_CMP && !match && more_scan) || state_reg == S_SH_WR)
        begin
            idx_reg <= idx_p1[CNT_W-1:0];
        end
    end

endmodule

FILE: tb/deque_shadow_check.sv
`timescale 1ns / 1ps
// Shadow deque that predicts each request's result and checks it when done strobes.
module deque_shadow_check
    import dqvs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [2:0]               req_type,
    input  logic signed [DATA_W-1:0] item_value,
    input  logic                     done,
    input  logic                     found,
    input  logic [1:0]               status,
    input  logic [CNT_W-1:0]         entry_count,
    input  logic signed [DATA_W-1:0] front_value,
    input  logic signed [DATA_W-1:0] back_value,
    output int                       mismatches,
    output int                       pending
);

    typedef struct packed {
        logic                     found;
        logic [1:0]               status;
        logic [CNT_W-1:0]         count;
        logic signed [DATA_W-1:0] front;
        logic signed [DATA_W-1:0] back;
    } deque_view_t;

    logic signed [DATA_W-1:0] held[$];     // front at index 0
    deque_view_t              expected_views[$];
    deque_view_t              want;
    int                       reported;

    initial
    begin
        mismatches = 0;
        pending    = 0;
        reported   = 0;
    end

    // Applies one request to the shadow deque and returns the view it should report.
    function automatic deque_view_t apply_request(input logic [2:0] code,
                                                  input logic signed [DATA_W-1:0] value);
        deque_view_t view;
        int          hit;
        view        = '0;
        view.status = ST_OK;
        hit         = -1;
        if (code == REQ_CONTAINS || code == REQ_REMOVE)
        begin
            for (int i = 0; i < held.size(); i++)
            begin
                if (hit < 0 && held[i] == value)
                    hit = i;
            end
        end
        case (code)
            REQ_PUSH_FRONT:
                if (held.size() >= DEPTH)
                    view.status = ST_FULL;
                else
                    held.push_front(value);
            REQ_PUSH_BACK:
                if (held.size() >= DEPTH)
                    view.status = ST_FULL;
                else
                    held.push_back(value);
            REQ_POP_FRONT:
                if (held.size() == 0)
                    view.status = ST_EMPTY;
                else
                    void'(held.pop_front());
            REQ_POP_BACK:
                if (held.size() == 0)
                    view.status = ST_EMPTY;
                else
                    void'(held.pop_back());
            REQ_CONTAINS:
                view.found = (hit >= 0);
            REQ_REMOVE:
                if (hit >= 0)
                begin
                    view.found = 1'b1;
                    held.delete(hit);
                end
            default:
                ;
        endcase
        view.count = CNT_W'(held.size());
        if (held.size() != 0)
        begin
            view.front = held[0];
            view.back  = held[held.size() - 1];
        end
        return view;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_views.size() == 0)
                begin
                    mismatches++;
                    if (reported < 10)
                        $display("%0t: unexpected done with no request outstanding", $time);
                    reported++;
                end
                else
                begin
                    want = expected_views.pop_front();
                    if (want.found !== found || want.status !== status ||
                        want.count !== entry_count || want.front !== front_value ||
                        want.back !== back_value)
                    begin
                        mismatches++;
                        if (reported < 10)
                            $display("%0t: mismatch exp found=%0b status=%0d count=%0d front=%0d back=%0d | got found=%0b status=%0d count=%0d front=%0d back=%0d",
                                     $time, want.found, want.status, want.count, want.front,
                                     want.back, found, status, entry_count, front_value,
                                     back_value);
                        reported++;
                    end
                end
            end
            if (start && !busy)
                expected_views.push_back(apply_request(req_type, item_value));
            pending = expected_views.size();
        end
    end

endmodule

FILE: tb/deque_with_value_search_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives deque requests, hosts the checker and prints the verdict.
module deque_with_value_search_tb
    import dqvs_pkg::*;
;

    // Codes the block must treat as no-ops.
    localparam logic [2:0] REQ_SPARE_LO = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    localparam int RANDOM_REQS = 450;
    localparam int SEGMENT_LEN = 30;   // requests per traffic mix
    localparam int CALM_TAIL   = 60;   // last requests go back to back
    localparam int DRAIN_AT    = 200;  // mid-run pause until all results are in
    // Worst request: scan or scan plus shift of a full deque.
    localparam int TAIL_CYCLES = 4 * DEPTH + 16;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_SEARCH
    } traffic_mix_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic [2:0]               req_type = '0;
    logic signed [DATA_W-1:0] item_value = '0;
    logic                     busy;
    logic                     done;
    logic                     found;
    logic [1:0]               status;
    logic [CNT_W-1:0]         entry_count;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    int                       mismatches;
    int                       pending;
    int                       cycle_count = 0;

    always #2 clk = ~clk;

    deque_with_value_search i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .item_value  (item_value),
        .done        (done),
        .found       (found),
        .status      (status),
        .entry_count (entry_count),
        .front_value (front_value),
        .back_value  (back_value)
    );

    deque_shadow_check i_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .item_value  (item_value),
        .done        (done),
        .found       (found),
        .status      (status),
        .entry_count (entry_count),
        .front_value (front_value),
        .back_value  (back_value),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Presents one request and returns right after the edge that accepts it.
    // busy is read at the falling edge, where it is settled; start stays high
    // so a following request can go out back to back.
    task automatic send_request(input logic [2:0] code,
                                input logic signed [DATA_W-1:0] value);
        logic ready;
        start      <= 1'b1;
        req_type   <= code;
        item_value <= value;
        ready = 1'b0;
        while (!ready)
        begin
            @(negedge clk);
            ready = !busy;
            @(posedge clk);
        end
    endtask

    // Sender gap; the request fields carry junk meanwhile, which must be ignored.
    task automatic idle_for(input int cycles);
        start      <= 1'b0;
        req_type   <= 3'($urandom);
        item_value <= $urandom;
        repeat (cycles) @(posedge clk);
    endtask

    // Holds off until every outstanding request has reported.
    task automatic drain_results();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // Values lean on a small pool so searches hit and duplicates pile up;
    // the rest are full-range random so every data bit toggles.
    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] value;
        case ($urandom_range(0, 9))
            0:       value = '0;
            1:       value = -1;
            2:       value = 32'sh7FFF_FFFF;
            3:       value = 32'sh8000_0000;
            4, 5, 6: value = $urandom_range(1, 4);
            default: value = $urandom;
        endcase
        return value;
    endfunction

    // Grow fills the deque toward full, shrink drains it toward empty,
    // search mostly exercises contains and remove on whatever is held.
    function automatic logic [2:0] pick_code(input traffic_mix_t mix);
        int roll;
        int push_pct;
        int pop_pct;
        int search_pct;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:
            begin
                push_pct   = 75;
                pop_pct    = 10;
                search_pct = 13;
            end
            MIX_SHRINK:
            begin
                push_pct   = 15;
                pop_pct    = 65;
                search_pct = 17;
            end
            default:
            begin
                push_pct   = 25;
                pop_pct    = 15;
                search_pct = 55;
            end
        endcase
        if (roll < push_pct)
            return $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
        if (roll < push_pct + pop_pct)
            return $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
        if (roll < push_pct + pop_pct + search_pct)
            return $urandom_range(0, 1) ? REQ_CONTAINS : REQ_REMOVE;
        return $urandom_range(0, 1) ? REQ_SPARE_LO : REQ_SPARE_HI;
    endfunction

    initial
    begin
        traffic_mix_t mix;
        mix = MIX_GROW;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Empty deque: pops flag empty, searches miss, spare codes do nothing.
        send_request(REQ_POP_FRONT, 32'sd0);
        send_request(REQ_POP_BACK, -32'sd1);
        send_request(REQ_CONTAINS, 32'sd0);
        send_request(REQ_REMOVE, 32'sd0);
        send_request(REQ_SPARE_LO, 32'sd7);
        send_request(REQ_SPARE_HI, 32'sd7);

        // Extremes at both ends, plus a duplicate zero.
        send_request(REQ_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_request(REQ_PUSH_BACK, 32'sh8000_0000);
        send_request(REQ_PUSH_FRONT, 32'sd0);
        send_request(REQ_PUSH_BACK, -32'sd1);
        send_request(REQ_PUSH_BACK, 32'sd0);

        // Hit and miss; remove takes the first zero only, then a middle entry.
        send_request(REQ_CONTAINS, -32'sd1);
        send_request(REQ_CONTAINS, 32'sd5);
        send_request(REQ_REMOVE, 32'sd0);
        send_request(REQ_REMOVE, 32'sh8000_0000);
        send_request(REQ_REMOVE, 32'sd12345);
        send_request(REQ_SPARE_HI, 32'sd0);

        // Pop back down to empty and once more past it.
        send_request(REQ_POP_BACK, 32'sd0);
        send_request(REQ_POP_FRONT, 32'sd0);
        send_request(REQ_POP_FRONT, 32'sd0);
        send_request(REQ_POP_BACK, 32'sd0);
        drain_results();

        // Random traffic in segments; a grow segment is forced regularly so
        // the deque reaches full, and a shrink one follows to empty it.
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if (n % SEGMENT_LEN == 0)
            begin
                case ((n / SEGMENT_LEN) % 5)
                    0:       mix = MIX_GROW;
                    1:       mix = MIX_SHRINK;
                    default: mix = traffic_mix_t'($urandom_range(0, 2));
                endcase
            end
            if (n == DRAIN_AT)
                drain_results();
            send_request(pick_code(mix), pick_value());
            if (n < RANDOM_REQS - CALM_TAIL && $urandom_range(0, 3) == 0)
                idle_for($urandom_range(1, 4));
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: deque_with_value_search.f
hw/rtl/dqvs_pkg.sv
hw/rtl/dqvs_ram.sv
hw/rtl/deque_with_value_search.sv
tb/deque_shadow_check.sv
tb/deque_with_value_search_tb.sv
